// File: src/apa_pkg.sv
package apa_pkg;

    // sizing of the page table and the pool
    localparam int MAX_PAGES    = 16;
    localparam int POOL_BYTES   = 1048576;
    localparam int ALIGN        = 8;
    localparam int DEFAULT_PAGE = 4096;

    localparam int IDX_W   = $clog2(MAX_PAGES);
    localparam int CNT_W   = $clog2(MAX_PAGES + 1);
    localparam int ADDR_W  = $clog2(POOL_BYTES);
    localparam int BYTE_W  = $clog2(POOL_BYTES + 1);
    localparam int ALIGN_W = $clog2(ALIGN);
    localparam int SIZE_W  = 32;
    localparam int NEED_W  = SIZE_W + 1;
    localparam int SET_W   = 21;
    localparam int PS_W    = SET_W + 1;

    localparam logic [BYTE_W-1:0] POOL_SIZE = BYTE_W'(POOL_BYTES);
    localparam logic [SET_W-1:0]  PAGE_DFLT_RESET = SET_W'(4096);

    // command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RESET   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // register indexes
    localparam logic REG_PAGE_DFLT = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] len;
        logic [ADDR_W-1:0] start;
    } geo_t;

    typedef struct packed {
        logic [IDX_W-1:0]  raddr;
        logic              geo_we;
        logic              fill_we;
        logic [IDX_W-1:0]  waddr;
        geo_t              geo_wdata;
        logic [BYTE_W-1:0] fill_wdata;
    } mem_req_t;

    // round a request up to the alignment
    function automatic logic [NEED_W-1:0] round_need(input logic [SIZE_W-1:0] size);
        logic [NEED_W-1:0] sum;
        sum = NEED_W'(size) + NEED_W'(ALIGN - 1);
        return {sum[NEED_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
    endfunction

    // page size used for a new page
    function automatic logic [PS_W-1:0] eff_page(input logic [SET_W-1:0] setting);
        logic [PS_W-1:0] sum;
        sum = PS_W'(setting) + PS_W'(ALIGN - 1);
        if (setting == '0)
            return PS_W'(DEFAULT_PAGE);
        return {sum[PS_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
    endfunction

    // free room in a page covers the request
    function automatic logic has_room(input logic [BYTE_W-1:0] len,
                                      input logic [BYTE_W-1:0] fill,
                                      input logic [NEED_W-1:0] need);
        logic [BYTE_W-1:0] left;
        left = len - fill;
        return need <= NEED_W'(left);
    endfunction

endpackage

// File: src/apa_page_mem.sv
module apa_page_mem
    import apa_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output geo_t              geo_rdata,
    output logic [BYTE_W-1:0] fill_rdata
);

    geo_t              geo_mem  [MAX_PAGES];
    logic [BYTE_W-1:0] fill_mem [MAX_PAGES];

    // page length and start
    always_ff @(posedge clk)
    begin
        if (req.geo_we)
        begin
            geo_mem[req.waddr] <= req.geo_wdata;
        end
        geo_rdata <= geo_mem[req.raddr];
    end

    // page fill
    always_ff @(posedge clk)
    begin
        if (req.fill_we)
        begin
            fill_mem[req.waddr] <= req.fill_wdata;
        end
        fill_rdata <= fill_mem[req.raddr];
    end

endmodule

// File: src/apa_cfg.sv
module apa_cfg
    import apa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [SET_W-1:0] page_dflt
);

    logic             reg_idx;
    logic             wr_en;
    logic [SET_W-1:0] page_dflt_reg;
    logic [SET_W-1:0] page_dflt_next;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_PAGE_DFLT);

    // page size register
    always_comb
    begin
        page_dflt_next = page_dflt_reg;
        if (wr_en)
        begin
            page_dflt_next = pwdata[SET_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_dflt_reg <= PAGE_DFLT_RESET;
        end
        else
        begin
            page_dflt_reg <= page_dflt_next;
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_PAGE_DFLT)
        begin
            prdata = 32'(page_dflt_reg);
        end
    end

    assign page_dflt = page_dflt_reg;

endmodule

// File: src/apa_ctrl.sv
module apa_ctrl
    import apa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SET_W-1:0]  page_dflt,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [SIZE_W-1:0] request_size,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] address,
    output logic [IDX_W-1:0]  page_index,
    output logic [ADDR_W-1:0] page_offset,
    output logic [BYTE_W-1:0] used_bytes,
    output logic [BYTE_W-1:0] capacity_bytes,
    output logic              out_of_memory,
    output mem_req_t          mem_req,
    input  geo_t              geo_rdata,
    input  logic [BYTE_W-1:0] fill_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CUR    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_NEW    = 3'd4;
    localparam logic [2:0] S_CLR    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [CNT_W-1:0]  open_reg, open_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [BYTE_W-1:0] top_reg, top_next;
    logic [BYTE_W-1:0] total_reg, total_next;
    logic              oom_reg, oom_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [BYTE_W-1:0] hit_fill_reg, hit_fill_next;
    logic [ADDR_W-1:0] hit_start_reg, hit_start_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [IDX_W-1:0]  res_page_reg, res_page_next;
    logic [ADDR_W-1:0] res_off_reg, res_off_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [IDX_W-1:0]  out_page_reg, out_page_next;
    logic [ADDR_W-1:0] out_off_reg, out_off_next;
    logic [BYTE_W-1:0] out_used_reg, out_used_next;
    logic [BYTE_W-1:0] out_cap_reg, out_cap_next;
    logic              out_oom_reg, out_oom_next;

    logic              in_fire;
    logic              out_free;
    logic              room_ok;
    logic [PS_W-1:0]   eff_ps;
    logic [NEED_W-1:0] new_len;
    logic [BYTE_W-1:0] pool_left;
    logic              new_fits;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // room check on the record just read, and new page sizing
    assign room_ok   = has_room(geo_rdata.len, fill_rdata, need_reg);
    assign eff_ps    = eff_page(page_dflt);
    assign new_len   = (need_reg > NEED_W'(eff_ps)) ? need_reg : NEED_W'(eff_ps);
    assign pool_left = POOL_SIZE - top_reg;
    assign new_fits  = (open_reg < CNT_W'(MAX_PAGES)) && (new_len <= NEED_W'(pool_left));

    // command sequencer
    always_comb
    begin
        state_next      = state_reg;
        need_next       = need_reg;
        open_next       = open_reg;
        cur_next        = cur_reg;
        top_next        = top_reg;
        total_next      = total_reg;
        oom_next        = oom_reg;
        idx_next        = idx_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_fill_next   = hit_fill_reg;
        hit_start_next  = hit_start_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_page_next   = res_page_reg;
        res_off_next    = res_off_reg;

        mem_req            = '0;
        mem_req.raddr      = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_status_next = ST_DONE;
                    res_addr_next   = '0;
                    res_page_next   = '0;
                    res_off_next    = '0;
                    state_next      = S_DONE;
                    case (command)
                        CMD_ALLOC:
                        begin
                            need_next = round_need(request_size);
                            if (request_size == '0)
                            begin
                                res_status_next = ST_ZERO;
                            end
                            else if (oom_reg)
                            begin
                                res_status_next = ST_OOM;
                            end
                            else if (CNT_W'(cur_reg) < open_reg)
                            begin
                                state_next = S_CUR;
                            end
                            else
                            begin
                                idx_next       = '0;
                                chk_valid_next = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        CMD_RESET:
                        begin
                            total_next = '0;
                            cur_next   = '0;
                            oom_next   = 1'b0;
                            idx_next   = '0;
                            state_next = S_CLR;
                        end
                        CMD_RELEASE:
                        begin
                            open_next  = '0;
                            cur_next   = '0;
                            top_next   = '0;
                            total_next = '0;
                            oom_next   = 1'b0;
                        end
                        default:
                        begin
                            res_status_next = ST_DONE;
                        end
                    endcase
                end
            end

            // current page record arrives
            S_CUR:
            begin
                if (room_ok)
                begin
                    hit_idx_next   = cur_reg;
                    hit_fill_next  = fill_rdata;
                    hit_start_next = geo_rdata.start;
                    state_next     = S_COMMIT;
                end
                else
                begin
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            // first-fit walk, one record read and one checked per cycle
            S_SCAN:
            begin
                mem_req.raddr = idx_reg[IDX_W-1:0];
                if (chk_valid_reg && room_ok)
                begin
                    hit_idx_next   = chk_idx_reg;
                    hit_fill_next  = fill_rdata;
                    hit_start_next = geo_rdata.start;
                    state_next     = S_COMMIT;
                end
                else if (idx_reg < open_reg)
                begin
                    idx_next       = idx_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_NEW;
                end
            end

            // bump an existing page
            S_COMMIT:
            begin
                mem_req.fill_we    = 1'b1;
                mem_req.waddr      = hit_idx_reg;
                mem_req.fill_wdata = hit_fill_reg + need_reg[BYTE_W-1:0];
                res_status_next    = ST_OK;
                res_addr_next      = hit_start_reg + hit_fill_reg[ADDR_W-1:0];
                res_page_next      = hit_idx_reg;
                res_off_next       = hit_fill_reg[ADDR_W-1:0];
                total_next         = total_reg + need_reg[BYTE_W-1:0];
                cur_next           = hit_idx_reg;
                state_next         = S_DONE;
            end

            // carve a new page off the pool top
            S_NEW:
            begin
                state_next = S_DONE;
                if (new_fits)
                begin
                    mem_req.geo_we          = 1'b1;
                    mem_req.fill_we         = 1'b1;
                    mem_req.waddr           = open_reg[IDX_W-1:0];
                    mem_req.geo_wdata.len   = new_len[BYTE_W-1:0];
                    mem_req.geo_wdata.start = top_reg[ADDR_W-1:0];
                    mem_req.fill_wdata      = need_reg[BYTE_W-1:0];
                    res_status_next         = ST_OK;
                    res_addr_next           = top_reg[ADDR_W-1:0];
                    res_page_next           = open_reg[IDX_W-1:0];
                    res_off_next            = '0;
                    top_next                = top_reg + new_len[BYTE_W-1:0];
                    open_next               = open_reg + 1'b1;
                    cur_next                = open_reg[IDX_W-1:0];
                    total_next              = total_reg + need_reg[BYTE_W-1:0];
                end
                else
                begin
                    oom_next        = 1'b1;
                    res_status_next = ST_OOM;
                end
            end

            // empty every open page, one per cycle
            S_CLR:
            begin
                if (idx_reg < open_reg)
                begin
                    mem_req.fill_we    = 1'b1;
                    mem_req.waddr      = idx_reg[IDX_W-1:0];
                    mem_req.fill_wdata = '0;
                    idx_next           = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_page_next   = out_page_reg;
        out_off_next    = out_off_reg;
        out_used_next   = out_used_reg;
        out_cap_next    = out_cap_reg;
        out_oom_next    = out_oom_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_addr_next   = res_addr_reg;
            out_page_next   = res_page_reg;
            out_off_next    = res_off_reg;
            out_used_next   = total_reg;
            out_cap_next    = top_reg;
            out_oom_next    = oom_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            open_reg      <= '0;
            cur_reg       <= '0;
            top_reg       <= '0;
            total_reg     <= '0;
            oom_reg       <= 1'b0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            cur_reg       <= cur_next;
            top_reg       <= top_next;
            total_reg     <= total_next;
            oom_reg       <= oom_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        need_reg       <= need_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_fill_reg   <= hit_fill_next;
        hit_start_reg  <= hit_start_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_page_reg   <= res_page_next;
        res_off_reg    <= res_off_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_page_reg   <= out_page_next;
        out_off_reg    <= out_off_next;
        out_used_reg   <= out_used_next;
        out_cap_reg    <= out_cap_next;
        out_oom_reg    <= out_oom_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign address        = out_addr_reg;
    assign page_index     = out_page_reg;
    assign page_offset    = out_off_reg;
    assign used_bytes     = out_used_reg;
    assign capacity_bytes = out_cap_reg;
    assign out_of_memory  = out_oom_reg;

endmodule

// File: src/paged_arena_allocator_top.sv
// channel   | handshake          | payload
// ----------+--------------------+------------------------------------------------
// in        | in_valid/in_stall  | command, request_size
// out       | out_valid/out_stall| status, address, page_index, page_offset,
//           |                    | used_bytes, capacity_bytes, out_of_memory
// config    | apb psel/penable   | paddr, pwdata, prdata (page size at byte 0)
//
// allocate: tries the current page first; when it does not fit, a first-fit walk over the
// page records follows, one record per cycle through the page memory read port.
// reset usage: one fill entry cleared per cycle.
// release, zero size, sticky out-of-memory and unused codes go straight to the result.
// one request is worked at a time; the next is taken while a result waits in the
// output register. rst_n clears all control state; page memory needs no clearing.
module paged_arena_allocator_top
    import apa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [SIZE_W-1:0] request_size,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] address,
    output logic [IDX_W-1:0]  page_index,
    output logic [ADDR_W-1:0] page_offset,
    output logic [BYTE_W-1:0] used_bytes,
    output logic [BYTE_W-1:0] capacity_bytes,
    output logic              out_of_memory,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [SET_W-1:0]  page_dflt;
    mem_req_t          mem_req;
    geo_t              geo_rdata;
    logic [BYTE_W-1:0] fill_rdata;

    apa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .page_dflt (page_dflt)
    );

    apa_page_mem u_mem (
        .clk        (clk),
        .req        (mem_req),
        .geo_rdata  (geo_rdata),
        .fill_rdata (fill_rdata)
    );

    apa_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .page_dflt      (page_dflt),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .request_size   (request_size),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .address        (address),
        .page_index     (page_index),
        .page_offset    (page_offset),
        .used_bytes     (used_bytes),
        .capacity_bytes (capacity_bytes),
        .out_of_memory  (out_of_memory),
        .mem_req        (mem_req),
        .geo_rdata      (geo_rdata),
        .fill_rdata     (fill_rdata)
    );

endmodule

// File: src/apa_checker.sv
module apa_checker
    import apa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        status,
    input logic [ADDR_W-1:0] address,
    input logic [IDX_W-1:0]  page_index,
    input logic [ADDR_W-1:0] page_offset,
    input logic [BYTE_W-1:0] used_bytes,
    input logic [BYTE_W-1:0] capacity_bytes,
    input logic              out_of_memory
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // failed or non-allocating requests carry no location
    a_no_loc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
            (address == '0) && (page_index == '0) && (page_offset == '0))
        else $error("location set on a non-allocating result");

    // used bytes never exceed the carved capacity
    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> used_bytes <= capacity_bytes)
        else $error("used bytes above capacity");

    // out-of-memory status always shows the sticky flag
    a_oom_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OOM) |-> out_of_memory)
        else $error("out-of-memory status without sticky flag");

    // a granted allocation never coexists with the sticky flag
    a_ok_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |-> !out_of_memory)
        else $error("allocation granted with sticky flag set");

endmodule

bind paged_arena_allocator_top apa_checker u_chk (.*);
